/* rtl/eight_bit_cpu_alu_with_flags_defines.svh */
// assertion macros used by the alu top file
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ealu_pkg.sv */
package ealu_pkg;

    // condition code bit positions
    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_V = 1;
    localparam int unsigned FL_Z = 2;
    localparam int unsigned FL_N = 3;
    localparam int unsigned FL_H = 5;

    // stream widths
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 24;

    // operation codes
    typedef enum logic [4:0] {
        OP_INC8   = 5'd0,
        OP_ADD8   = 5'd1,
        OP_ADC8   = 5'd2,
        OP_ADD16  = 5'd3,
        OP_SUB8   = 5'd4,
        OP_SBC8   = 5'd5,
        OP_DEC8   = 5'd6,
        OP_SUB16  = 5'd7,
        OP_OR     = 5'd8,
        OP_AND    = 5'd9,
        OP_ROL    = 5'd10,
        OP_ROR    = 5'd11,
        OP_ASR    = 5'd12,
        OP_LSL    = 5'd13,
        OP_LSR    = 5'd14,
        OP_MUL    = 5'd15,
        OP_MOV8   = 5'd16,
        OP_MOV16  = 5'd17,
        OP_TST8   = 5'd18,
        OP_NEG    = 5'd19,
        OP_CLR    = 5'd20,
        OP_COM    = 5'd21,
        OP_EOR    = 5'd22,
        OP_TSTZ16 = 5'd23,
        OP_SEX    = 5'd24,
        OP_DAA    = 5'd25
    } alu_op_t;

    // one operation request
    typedef struct packed {
        logic [7:0]  flags_in;
        logic [4:0]  opcode;
        logic [15:0] operand_b;
        logic [15:0] operand_a;
    } alu_in_t;

    // one operation outcome
    typedef struct packed {
        logic        bad_opcode;
        logic [7:0]  flags_out;
        logic [15:0] result;
    } alu_out_t;

endpackage

/* rtl/eight_bit_cpu_alu_with_flags.sv */
// an accepted input beat goes through the input register, then the result register, to its result beat on m_
// throughput: one operation per cycle while m_tready is high, set by the input and result registers
// the input stage refills while a finished result waits in the result register
// reset: synchronous active-low aresetn clears both stage valid flags only
`include "eight_bit_cpu_alu_with_flags_defines.svh"

module eight_bit_cpu_alu_with_flags
    import ealu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // operand_a[15:0], operand_b[31:16], opcode[36:32], flags_in[44:37], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // result[15:0], flags_out[23:16]
    output logic [M_DATA_W-1:0] m_tdata,
    // bad_opcode[0]
    output logic                m_tuser
);

    alu_in_t  in_reg;
    alu_in_t  in_next;
    logic     in_valid_reg;
    logic     in_valid_next;
    alu_out_t out_reg;
    alu_out_t out_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     s_beat;
    logic     out_load;

    // stage advance control
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign s_beat   = s_tvalid && s_tready;

    // unpack input beat
    assign in_next.operand_a = s_tdata[15:0];
    assign in_next.operand_b = s_tdata[31:16];
    assign in_next.opcode    = s_tdata[36:32];
    assign in_next.flags_in  = s_tdata[44:37];

    assign in_valid_next  = s_beat || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    // operation logic between the two registers
    ealu_exec u_exec (
        .op_i  (in_reg),
        .res_o (out_next)
    );

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_reg <= in_next;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.flags_out, out_reg.result};
    assign m_tuser  = out_reg.bad_opcode;

    // checks
    `EALU_ASSERT_NEXT(a_in_taken, s_beat, in_valid_reg, "accepted beat did not enter input stage")
    `EALU_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid, "loaded result did not show on m_ side")
    `EALU_ASSERT_NOW(a_bad_zero, m_tvalid && m_tuser, m_tdata[15:0] == 16'd0, "bad opcode with nonzero result")
    `EALU_ASSERT_NEXT(a_bad_flags, out_load && (in_reg.opcode > OP_DAA), m_tuser && (m_tdata[23:16] == $past(in_reg.flags_in)), "bad opcode changed flags")
    `EALU_ASSERT_NEXT(a_in_hold, in_valid_reg && !out_load, $stable(in_reg), "input stage changed while stalled")

endmodule

/* rtl/ealu_exec.sv */
module ealu_exec
    import ealu_pkg::*;
(
    input  alu_in_t  op_i,
    output alu_out_t res_o
);

    alu_op_t     op;
    logic [15:0] a16;
    logic [15:0] b16;
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic [7:0]  add8;
    logic [7:0]  sub8;
    logic [15:0] add16;
    logic [15:0] sub16;
    logic [15:0] prod;
    logic [8:0]  daa_lo;
    logic [8:0]  daa_hi;
    logic [15:0] r;
    logic [7:0]  cc;
    logic        bad;

    // carry out of an add at the top bit
    function automatic logic add_c(input logic x, input logic y, input logic s);
        return (x & y) | (x & ~s) | (y & ~s);
    endfunction

    function automatic logic add_v(input logic x, input logic y, input logic s);
        return (x & y & ~s) | (~x & ~y & s);
    endfunction

    // borrow out of a subtract at the top bit
    function automatic logic sub_c(input logic x, input logic y, input logic s);
        return (~x & y) | (~x & s) | (y & s);
    endfunction

    function automatic logic sub_v(input logic x, input logic y, input logic s);
        return (~x & y & s) | (x & ~y & ~s);
    endfunction

    // operand views and shared adders
    assign op    = alu_op_t'(op_i.opcode);
    assign a16   = op_i.operand_a;
    assign b16   = op_i.operand_b;
    assign a8    = a16[7:0];
    assign b8    = b16[7:0];
    assign cin   = op_i.flags_in[FL_C];
    assign add8  = a8 + b8 + ((op == OP_ADC8) ? {7'd0, cin} : 8'd0);
    assign sub8  = a8 - b8 - ((op == OP_SBC8) ? {7'd0, cin} : 8'd0);
    assign add16 = a16 + b16;
    assign sub16 = a16 - b16;
    assign prod  = a8 * b8;

    // decimal adjust in two correction steps
    assign daa_lo = ((a8[3:0] > 4'd9) || op_i.flags_in[FL_H]) ?
                    ({1'b0, a8} + 9'h006) : {1'b0, a8};
    assign daa_hi = ((daa_lo[8:4] > 5'd9) || cin) ? (daa_lo + 9'h060) : daa_lo;

    // result and flag update per operation
    always_comb begin
        r   = 16'd0;
        cc  = op_i.flags_in;
        bad = 1'b0;
        unique case (op) inside
            OP_INC8: begin
                r[7:0]   = a8 + 8'd1;
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_V] = (a8 == 8'h7f);
            end
            OP_ADD8, OP_ADC8: begin
                r[7:0]   = add8;
                cc[FL_Z] = (add8 == 8'd0);
                cc[FL_N] = add8[7];
                cc[FL_V] = add_v(a8[7], b8[7], add8[7]);
                cc[FL_C] = add_c(a8[7], b8[7], add8[7]);
                cc[FL_H] = add_c(a8[3], b8[3], add8[3]);
            end
            OP_ADD16: begin
                r        = add16;
                cc[FL_Z] = (add16 == 16'd0);
                cc[FL_N] = add16[15];
                cc[FL_V] = add_v(a16[15], b16[15], add16[15]);
                cc[FL_C] = add_c(a16[15], b16[15], add16[15]);
            end
            OP_SUB8, OP_SBC8: begin
                r[7:0]   = sub8;
                cc[FL_Z] = (sub8 == 8'd0);
                cc[FL_N] = sub8[7];
                cc[FL_V] = sub_v(a8[7], b8[7], sub8[7]);
                cc[FL_C] = sub_c(a8[7], b8[7], sub8[7]);
            end
            OP_DEC8: begin
                r[7:0]   = a8 - 8'd1;
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_V] = (a8 == 8'h80);
            end
            OP_SUB16: begin
                r        = sub16;
                cc[FL_Z] = (sub16 == 16'd0);
                cc[FL_N] = sub16[15];
                cc[FL_V] = sub_v(a16[15], b16[15], sub16[15]);
                cc[FL_C] = sub_c(a16[15], b16[15], sub16[15]);
            end
            OP_OR, OP_AND, OP_EOR, OP_MOV8, OP_TST8: begin
                if (op == OP_OR) begin
                    r[7:0] = a8 | b8;
                end else if (op == OP_AND) begin
                    r[7:0] = a8 & b8;
                end else if (op == OP_EOR) begin
                    r[7:0] = a8 ^ b8;
                end else begin
                    r[7:0] = a8;
                end
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_V] = 1'b0;
            end
            OP_ROL, OP_LSL: begin
                r[7:0]   = {a8[6:0], (op == OP_ROL) ? cin : 1'b0};
                cc[FL_C] = a8[7];
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_V] = a8[7] ^ r[7];
            end
            OP_ROR, OP_ASR: begin
                r[7:0]   = {(op == OP_ROR) ? cin : a8[7], a8[7:1]};
                cc[FL_C] = a8[0];
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
            end
            OP_LSR: begin
                r[7:0]   = {1'b0, a8[7:1]};
                cc[FL_C] = a8[0];
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = 1'b0;
            end
            OP_MUL: begin
                r        = prod;
                cc[FL_Z] = (prod == 16'd0);
                cc[FL_C] = prod[7];
            end
            OP_MOV16: begin
                r        = a16;
                cc[FL_Z] = (a16 == 16'd0);
                cc[FL_N] = a16[15];
                cc[FL_V] = 1'b0;
            end
            OP_NEG: begin
                r[7:0]   = 8'd0 - a8;
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_C] = (a8 != 8'd0);
                cc[FL_V] = (a8 == 8'h80);
            end
            OP_CLR: begin
                cc[FL_Z] = 1'b1;
                cc[FL_V] = 1'b0;
                cc[FL_N] = 1'b0;
                cc[FL_C] = 1'b0;
            end
            OP_COM: begin
                r[7:0]   = ~a8;
                cc[FL_Z] = (r[7:0] == 8'd0);
                cc[FL_N] = r[7];
                cc[FL_V] = 1'b0;
                cc[FL_C] = 1'b1;
            end
            OP_TSTZ16: begin
                r        = a16;
                cc[FL_Z] = (a16 == 16'd0);
            end
            OP_SEX: begin
                r[7:0]   = {8{a8[7]}};
                cc[FL_Z] = ~a8[7];
                cc[FL_N] = a8[7];
            end
            OP_DAA: begin
                r[7:0]   = daa_hi[7:0];
                if (daa_hi[8]) begin
                    cc[FL_C] = 1'b1;
                end
                cc[FL_Z] = (daa_hi[7:0] == 8'd0);
                cc[FL_N] = daa_hi[7];
                cc[FL_V] = 1'b0;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    assign res_o.result     = r;
    assign res_o.flags_out  = cc;
    assign res_o.bad_opcode = bad;

endmodule

/* tb/alu_flag_checker.sv */
module alu_flag_checker
    import ealu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // operand_a[15:0], operand_b[31:16], opcode[36:32], flags_in[44:37], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // result[15:0], flags_out[23:16]
    input  logic [M_DATA_W-1:0] m_tdata,
    // bad_opcode[0]
    input  logic                m_tuser,
    output int                  fail_count,
    output int                  pending_count,
    output int                  checked_count
);

    alu_out_t expected_q[$];
    int       fails  = 0;
    int       checks = 0;

    // negative and zero from an 8-bit result
    function automatic logic [7:0] with_nz8(logic [7:0] cc, logic [7:0] r);
        cc[FL_Z] = (r == 8'h00);
        cc[FL_N] = r[7];
        return cc;
    endfunction

    // negative and zero from a 16-bit result
    function automatic logic [7:0] with_nz16(logic [7:0] cc, logic [15:0] r);
        cc[FL_Z] = (r == 16'h0000);
        cc[FL_N] = r[15];
        return cc;
    endfunction

    // overflow and carry/borrow from the top bits of operands and result
    function automatic logic [7:0] with_vc(logic [7:0] cc, logic xs, logic ys, logic rs,
                                           logic is_sub);
        if (!is_sub) begin
            cc[FL_V] = (xs & ys & ~rs) | (~xs & ~ys & rs);
            cc[FL_C] = (xs & ys) | (xs & ~rs) | (ys & ~rs);
        end else begin
            cc[FL_V] = (~xs & ys & rs) | (xs & ~ys & ~rs);
            cc[FL_C] = (~xs & ys) | (~xs & rs) | (ys & rs);
        end
        return cc;
    endfunction

    // expected outcome of one alu operation
    function automatic alu_out_t alu_predict(alu_in_t req);
        alu_out_t    res;
        logic [7:0]  a, b, r8, cc;
        logic [15:0] r16;
        logic [9:0]  dec;
        logic        cin;
        a   = req.operand_a[7:0];
        b   = req.operand_b[7:0];
        cc  = req.flags_in;
        cin = cc[FL_C];
        r16 = '0;
        res.bad_opcode = 1'b0;
        case (alu_op_t'(req.opcode)) inside
            OP_INC8: begin
                r8 = a + 8'd1;
                cc = with_nz8(cc, r8);
                cc[FL_V] = (a == 8'h7f);
                r16 = {8'h00, r8};
            end
            OP_ADD8, OP_ADC8: begin
                r8 = a + b + ((alu_op_t'(req.opcode) == OP_ADC8) ? {7'd0, cin} : 8'd0);
                cc = with_nz8(cc, r8);
                cc = with_vc(cc, a[7], b[7], r8[7], 1'b0);
                cc[FL_H] = (a[3] & b[3]) | (a[3] & ~r8[3]) | (b[3] & ~r8[3]);
                r16 = {8'h00, r8};
            end
            OP_ADD16: begin
                r16 = req.operand_a + req.operand_b;
                cc = with_nz16(cc, r16);
                cc = with_vc(cc, req.operand_a[15], req.operand_b[15], r16[15], 1'b0);
            end
            OP_SUB8, OP_SBC8: begin
                r8 = a - b - ((alu_op_t'(req.opcode) == OP_SBC8) ? {7'd0, cin} : 8'd0);
                cc = with_nz8(cc, r8);
                cc = with_vc(cc, a[7], b[7], r8[7], 1'b1);
                r16 = {8'h00, r8};
            end
            OP_DEC8: begin
                r8 = a - 8'd1;
                cc = with_nz8(cc, r8);
                cc[FL_V] = (a == 8'h80);
                r16 = {8'h00, r8};
            end
            OP_SUB16: begin
                r16 = req.operand_a - req.operand_b;
                cc = with_nz16(cc, r16);
                cc = with_vc(cc, req.operand_a[15], req.operand_b[15], r16[15], 1'b1);
            end
            OP_OR, OP_AND, OP_EOR, OP_MOV8, OP_TST8: begin
                case (alu_op_t'(req.opcode))
                    OP_OR:   r8 = a | b;
                    OP_AND:  r8 = a & b;
                    OP_EOR:  r8 = a ^ b;
                    default: r8 = a;
                endcase
                cc = with_nz8(cc, r8);
                cc[FL_V] = 1'b0;
                r16 = {8'h00, r8};
            end
            OP_ROL, OP_LSL: begin
                r8 = {a[6:0], (alu_op_t'(req.opcode) == OP_ROL) ? cin : 1'b0};
                cc[FL_C] = a[7];
                cc = with_nz8(cc, r8);
                cc[FL_V] = a[7] ^ r8[7];
                r16 = {8'h00, r8};
            end
            OP_ROR, OP_ASR: begin
                r8 = {(alu_op_t'(req.opcode) == OP_ROR) ? cin : a[7], a[7:1]};
                cc[FL_C] = a[0];
                cc = with_nz8(cc, r8);
                r16 = {8'h00, r8};
            end
            OP_LSR: begin
                r8 = {1'b0, a[7:1]};
                cc[FL_C] = a[0];
                cc[FL_Z] = (r8 == 8'h00);
                cc[FL_N] = 1'b0;
                r16 = {8'h00, r8};
            end
            OP_MUL: begin
                // full 16-bit product, carry taken from bit 7
                r16 = a * b;
                cc[FL_Z] = (r16 == 16'h0000);
                cc[FL_C] = r16[7];
            end
            OP_MOV16: begin
                r16 = req.operand_a;
                cc = with_nz16(cc, r16);
                cc[FL_V] = 1'b0;
            end
            OP_NEG: begin
                r8 = 8'h00 - a;
                cc = with_nz8(cc, r8);
                cc[FL_C] = (a != 8'h00);
                cc[FL_V] = (a == 8'h80);
                r16 = {8'h00, r8};
            end
            OP_CLR: begin
                cc[FL_Z] = 1'b1;
                cc[FL_V] = 1'b0;
                cc[FL_N] = 1'b0;
                cc[FL_C] = 1'b0;
            end
            OP_COM: begin
                r8 = ~a;
                cc = with_nz8(cc, r8);
                cc[FL_V] = 1'b0;
                cc[FL_C] = 1'b1;
                r16 = {8'h00, r8};
            end
            OP_TSTZ16: begin
                r16 = req.operand_a;
                cc[FL_Z] = (r16 == 16'h0000);
            end
            OP_SEX: begin
                r8 = a[7] ? 8'hff : 8'h00;
                cc = with_nz8(cc, r8);
                r16 = {8'h00, r8};
            end
            OP_DAA: begin
                // carry can only be set here, never cleared
                dec = {2'b00, a};
                if (dec[3:0] > 4'd9 || cc[FL_H])
                    dec = dec + 10'h006;
                if ((dec >> 4) > 10'd9 || cin)
                    dec = dec + 10'h060;
                if (dec[8])
                    cc[FL_C] = 1'b1;
                r8 = dec[7:0];
                cc = with_nz8(cc, r8);
                cc[FL_V] = 1'b0;
                r16 = {8'h00, r8};
            end
            default: begin
                res.bad_opcode = 1'b1;
            end
        endcase
        res.result    = r16;
        res.flags_out = cc;
        return res;
    endfunction

    // compare result beats in order, then queue the prediction for an input beat
    always @(posedge aclk) begin : watch
        alu_out_t got;
        alu_out_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = alu_out_t'({m_tuser, m_tdata});
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", got);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    checks++;
                    if (got.result !== want.result) begin
                        $error("result: expected %h, actual %h", want.result, got.result);
                        fails++;
                    end
                    if (got.flags_out !== want.flags_out) begin
                        $error("flags_out: expected %h, actual %h",
                               want.flags_out, got.flags_out);
                        fails++;
                    end
                    if (got.bad_opcode !== want.bad_opcode) begin
                        $error("bad_opcode: expected %b, actual %b",
                               want.bad_opcode, got.bad_opcode);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(alu_predict(alu_in_t'(s_tdata[44:0])));
        end
        fail_count    <= fails;
        pending_count <= expected_q.size();
        checked_count <= checks;
    end

endmodule

/* tb/tb.sv */
module tb;
    import ealu_pkg::*;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent      = 0;
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    eight_bit_cpu_alu_with_flags uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    alu_flag_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #5 aclk = ~aclk;

    // offer one operation beat and hold it until accepted, then maybe idle
    task automatic issue_op(input logic [15:0] a, input logic [15:0] b,
                            input logic [4:0] op, input logic [7:0] fl);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, fl, op, b, a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // operands biased toward the edges of the 8- and 16-bit ranges
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h0080 | (16'($urandom) & 16'hff00);
            3: return 16'h007f | (16'($urandom) & 16'hff00);
            4: return 16'h8000 | (16'($urandom) & 16'h00ff);
            5: return {8'($urandom_range(0, 255)), 8'h00};
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin : sink
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stim
        logic [4:0] op;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: edge values for every operation
        issue_op(16'h007f, 16'h0000, OP_INC8,   8'h00);
        issue_op(16'h00ff, 16'h0001, OP_ADD8,   8'h00);
        issue_op(16'h007f, 16'h0080, OP_ADC8,   8'hff);
        issue_op(16'hffff, 16'h0001, OP_ADD16,  8'h00);
        issue_op(16'h0000, 16'h0001, OP_SUB8,   8'h00);
        issue_op(16'h0080, 16'h007f, OP_SBC8,   8'h01);
        issue_op(16'h0080, 16'h0000, OP_DEC8,   8'h00);
        issue_op(16'h8000, 16'h0001, OP_SUB16,  8'h00);
        issue_op(16'h00f0, 16'h000f, OP_OR,     8'hff);
        issue_op(16'h00f0, 16'h000f, OP_AND,    8'h00);
        issue_op(16'h0080, 16'h0000, OP_ROL,    8'h01);
        issue_op(16'h0001, 16'h0000, OP_ROR,    8'h01);
        issue_op(16'h0081, 16'h0000, OP_ASR,    8'h00);
        issue_op(16'h00c0, 16'h0000, OP_LSL,    8'h00);
        issue_op(16'h0001, 16'h0000, OP_LSR,    8'hff);
        issue_op(16'hffff, 16'hffff, OP_MUL,    8'h00);
        issue_op(16'hff00, 16'h0000, OP_MOV8,   8'h00);
        issue_op(16'h0000, 16'hffff, OP_MOV16,  8'hff);
        issue_op(16'h00ff, 16'h0000, OP_TST8,   8'h02);
        issue_op(16'h0080, 16'h0000, OP_NEG,    8'h00);
        issue_op(16'h0000, 16'h0000, OP_NEG,    8'hff);
        issue_op(16'hffff, 16'hffff, OP_CLR,    8'hff);
        issue_op(16'h00ff, 16'h0000, OP_COM,    8'h00);
        issue_op(16'h00aa, 16'h0055, OP_EOR,    8'h00);
        issue_op(16'h0000, 16'hffff, OP_TSTZ16, 8'h00);
        issue_op(16'h0080, 16'h0000, OP_SEX,    8'h00);
        issue_op(16'h009a, 16'h0000, OP_DAA,    8'h20);
        issue_op(16'hffff, 16'hffff, 5'd31,     8'h5a);

        // random operations, a few unknown opcodes mixed in
        for (int i = 0; i < 1000; i++) begin
            if (i == 400)
                hold_req = 1'b1;
            if (i == 850)
                quiet = 1'b1;
            op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(26, 31))
                                              : 5'($urandom_range(0, 25));
            issue_op(pick_operand(), pick_operand(), op, 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then a short tail
        while (pending_count != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d alu operations over all opcodes, %0d results checked", sent,
                 checked_count);
        $display("random idle on both ports, one long result stall, a quiet final stretch");
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
